@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, quiet while reset is held
`define SWPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check that also holds while reset is held
`define SWPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/swpp_pkg.sv @@
package swpp_pkg;

  // window size register
  localparam int unsigned CfgW     = 9;
  localparam logic [CfgW-1:0] WinReset = 9'd1;

  // width of the range fields on the result channel
  localparam int unsigned OutW = 16;

  // entries in the queue between front and tree walker
  localparam int unsigned QueueDepth = 2;

endpackage

@@ rtl/core/sliding_window_peak_to_peak.sv @@
// sliding window peak to peak: each accepted sample beat gives one result beat with the
// window's max minus min (window_full_o low and range 0 until window_size samples of the
// sequence have arrived) and the best range since the last start_req_i. the user must see
// that window_size is written through the cfg channel only while the block is idle; the
// block itself does not enforce it. 0 acts as 1, anything above MAX_WINDOW acts as
// MAX_WINDOW. in the tree walker a sample is first taken from the queue, then the walk
// climbs one tree level at a time as the single node store writes the path node and reads
// its sibling, and last comes the range and best compare. the front and a two-beat queue
// keep taking samples while the walker is busy or a result waits to be taken, until the
// queue is full. start_req_i clears the tree at once through a written-slot mark, so there is no clearing pass

module sliding_window_peak_to_peak import swpp_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // window size register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_window_size_i,
  // sample beats
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   start_req_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   window_full_o,
  output logic [OutW-1:0]        window_range_o,
  output logic [OutW-1:0]        best_range_o
);

  localparam int unsigned SlotW = $clog2(MAX_WINDOW);
  localparam int unsigned HiW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmdW  = SAMPLE_BITS + SlotW + HiW + 2;

  // front to queue
  logic            fq_valid;
  logic            fq_ready;
  logic [CmdW-1:0] fq_data;
  // queue to tree walker
  logic            qt_valid;
  logic            qt_ready;
  logic [CmdW-1:0] qt_data;

  // front: window register, slot pointer, fill count, fullness per beat
  swpp_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .start_req_i       (start_req_i),
    .cmd_valid_o       (fq_valid),
    .cmd_ready_i       (fq_ready),
    .cmd_o             (fq_data)
  );

  // short queue so the front keeps taking beats while the walker runs
  swpp_cmd_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qt_valid),
    .pop_ready_i  (qt_ready),
    .pop_data_o   (qt_data)
  );

  // back: leaf-to-root walk over the max/min tree, range and best, result register
  swpp_tree #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tree (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (qt_valid),
    .cmd_ready_o    (qt_ready),
    .cmd_i          (qt_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .window_full_o  (window_full_o),
    .window_range_o (window_range_o),
    .best_range_o   (best_range_o)
  );

endmodule

@@ rtl/core/swpp_cmd_fifo.sv @@
`include "assert_macros.svh"

module swpp_cmd_fifo #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 2,
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SWPP_ASSERT(a_fill_in_bounds, cnt_q <= CntW'(Depth), "queue fill beyond depth")
  `SWPP_ASSERT(a_fill_tracks_push, $past(rst_ni) && $past(push && !pop) |-> cnt_q == $past(cnt_q) + CntW'(1), "queue fill did not grow on push")
  `SWPP_ASSERT(a_fill_tracks_pop, $past(rst_ni) && $past(pop && !push) |-> cnt_q == $past(cnt_q) - CntW'(1), "queue fill did not shrink")

endmodule

@@ rtl/core/swpp_front.sv @@
module swpp_front import swpp_pkg::*; #(
  parameter  int unsigned MAX_WINDOW  = 256,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned SlotW       = $clog2(MAX_WINDOW),
  localparam int unsigned HiW         = $clog2(MAX_WINDOW + 1),
  localparam int unsigned CmdW        = SAMPLE_BITS + SlotW + HiW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_window_size_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   start_req_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output logic [CmdW-1:0]        cmd_o
);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [SlotW-1:0]       slot;
    logic [HiW-1:0]         hi;
    logic                   full;
    logic                   start;
  } cmd_t;

  logic [CfgW-1:0]  win_q;
  logic [HiW-1:0]   eff_size;
  logic [SlotW-1:0] slot_q, slot_d, slot_base, slot_cur;
  logic [HiW-1:0]   fill_q, fill_d, fill_base;
  logic [HiW-1:0]   hi_q, hi_d, hi_base;
  logic [HiW-1:0]   slot_inc;
  logic             accept;
  cmd_t             cmd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= cfg_window_size_i;
    end
  end

  // zero acts as one, oversize clamps to the slot count
  always_comb begin
    if (win_q == '0) begin
      eff_size = HiW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      eff_size = HiW'(MAX_WINDOW);
    end else begin
      eff_size = HiW'(win_q);
    end
  end

  always_comb begin
    slot_base = start_req_i ? '0 : slot_q;
    fill_base = start_req_i ? '0 : fill_q;
    hi_base   = start_req_i ? '0 : hi_q;
    // pointer left beyond a shrunk window wraps to slot 0
    slot_cur  = (HiW'(slot_base) >= eff_size) ? '0 : slot_base;
    slot_inc  = HiW'(slot_cur) + HiW'(1);
    slot_d    = (slot_inc >= eff_size) ? '0 : slot_inc[SlotW-1:0];
    fill_d    = (fill_base < eff_size) ? fill_base + HiW'(1) : fill_base;
    // written slots always form a prefix, so one mark covers them
    hi_d      = (slot_inc > hi_base) ? slot_inc : hi_base;

    cmd.sample = sample_i;
    cmd.slot   = slot_cur;
    cmd.hi     = hi_d;
    cmd.full   = (fill_d >= eff_size);
    cmd.start  = start_req_i;
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      hi_q   <= '0;
    end else if (accept) begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      hi_q   <= hi_d;
    end
  end

endmodule

@@ rtl/core/swpp_tree.sv @@
`include "assert_macros.svh"

module swpp_tree import swpp_pkg::*; #(
  parameter  int unsigned MAX_WINDOW  = 256,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned SlotW       = $clog2(MAX_WINDOW),
  localparam int unsigned HiW         = $clog2(MAX_WINDOW + 1),
  localparam int unsigned CmdW        = SAMPLE_BITS + SlotW + HiW + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic [CmdW-1:0] cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            window_full_o,
  output logic [OutW-1:0] window_range_o,
  output logic [OutW-1:0] best_range_o
);

  localparam int unsigned AddrW = $clog2(2 * MAX_WINDOW);
  localparam int unsigned WideW = 2 * AddrW + 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [SlotW-1:0]       slot;
    logic [HiW-1:0]         hi;
    logic                   full;
    logic                   start;
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mx;
    logic [SAMPLE_BITS-1:0] mn;
  } node_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

  // a node counts only if one of its leaves was written this sequence
  function automatic logic node_live(input logic [AddrW-1:0] idx, input logic [HiW-1:0] hi);
    logic [WideW-1:0] lo_b;
    logic [WideW-1:0] hi_b;
    logic [WideW-1:0] first;
    logic [WideW-1:0] last;
    logic             live;
    live = 1'b0;
    lo_b = WideW'(MAX_WINDOW);
    hi_b = WideW'(MAX_WINDOW) + WideW'(hi);
    for (int k = 0; k < AddrW; k++) begin
      first = WideW'(idx) << k;
      last  = (WideW'(idx) + WideW'(1)) << k;
      if (first < hi_b && last > lo_b) begin
        live = 1'b1;
      end
    end
    return live;
  endfunction

  node_t                  node_mem [2 * MAX_WINDOW];
  cmd_t                   cmd;
  state_e                 state_q, state_d;
  logic [AddrW-1:0]       pos_q;
  node_t                  cur_q;
  node_t                  sib_q;
  node_t                  sib_eff;
  node_t                  node_val;
  logic                   sib_ok_q;
  logic                   have_sib_q;
  logic [HiW-1:0]         hi_q;
  logic                   full_q;
  logic [SAMPLE_BITS-1:0] best_q;
  logic [SAMPLE_BITS-1:0] range_val;
  logic [SAMPLE_BITS-1:0] best_val;
  logic                   out_valid_q;
  logic                   out_full_q;
  logic [SAMPLE_BITS-1:0] out_range_q;
  logic [SAMPLE_BITS-1:0] out_best_q;
  logic                   load_out;

  assign cmd         = cmd_i;
  assign cmd_ready_o = (state_q == StIdle);
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // parent from the path value and the sibling read last cycle
  always_comb begin
    sib_eff.mx = sib_ok_q ? sib_q.mx : '0;
    sib_eff.mn = sib_ok_q ? sib_q.mn : '1;
    node_val   = cur_q;
    if (have_sib_q) begin
      node_val.mx = (sib_eff.mx > cur_q.mx) ? sib_eff.mx : cur_q.mx;
      node_val.mn = (sib_eff.mn < cur_q.mn) ? sib_eff.mn : cur_q.mn;
    end
  end

  always_comb begin
    range_val = (cur_q.mx >= cur_q.mn) ? cur_q.mx - cur_q.mn : '0;
    best_val  = (full_q && range_val > best_q) ? range_val : best_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (pos_q == AddrW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_sib_q  <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          have_sib_q <= 1'b0;
          if (cmd_valid_i && cmd.start) begin
            best_q <= '0;
          end
        end
        StWalk: begin
          have_sib_q <= 1'b1;
        end
        StDone: begin
          if (load_out) begin
            best_q <= best_val;
          end
        end
        default: have_sib_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      pos_q  <= AddrW'(MAX_WINDOW) + AddrW'(cmd.slot);
      cur_q  <= '{mx: cmd.sample, mn: cmd.sample};
      hi_q   <= cmd.hi;
      full_q <= cmd.full;
    end else if (state_q == StWalk) begin
      pos_q    <= pos_q >> 1;
      cur_q    <= node_val;
      sib_ok_q <= node_live(pos_q ^ AddrW'(1), hi_q);
    end
    if (load_out) begin
      out_full_q  <= full_q;
      out_range_q <= full_q ? range_val : '0;
      out_best_q  <= best_val;
    end
  end

  // node store: write the path node, read its sibling for the next level
  always_ff @(posedge clk_i) begin
    if (state_q == StWalk) begin
      node_mem[pos_q] <= node_val;
      sib_q           <= node_mem[pos_q ^ AddrW'(1)];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_full_o  = out_full_q;
  assign window_range_o = OutW'(out_range_q);
  assign best_range_o   = OutW'(out_best_q);

  `SWPP_ASSERT(a_range_zero_unfilled, out_valid_o && !out_full_q |-> out_range_q == '0, "range shown before window filled")
  `SWPP_ASSERT(a_best_covers_range, out_valid_o && out_full_q |-> out_best_q >= out_range_q, "best range below current range")
  `SWPP_ASSERT(a_walk_ends_at_root, $past(rst_ni) && state_q == StDone && $past(state_q) == StWalk |-> $past(pos_q) == AddrW'(1), "walk left before reaching the root")

endmodule
